@@ hdl/traffic_green_phase_scheduler_assert.svh @@
// assertion macros shared by the scheduler rtl
`ifndef TRAFFIC_GREEN_PHASE_SCHEDULER_ASSERT_SVH
`define TRAFFIC_GREEN_PHASE_SCHEDULER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TGPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define TGPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tgps_pkg.sv @@
package tgps_pkg;

	// item action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_SERVE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// register indexes, taken from paddr[2]
	localparam logic REG_CARS_PER_GREEN = 1'b0;
	localparam logic REG_GREEN_SECONDS  = 1'b1;

	localparam logic [7:0] CARS_PER_GREEN_RESET = 8'd5;
	localparam logic [7:0] GREEN_SECONDS_RESET  = 8'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ready;
		logic scan;
		logic drain;
		logic finish;
	} ctl_t;

endpackage

@@ hdl/tgps_alu.sv @@
module tgps_alu #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         gt,
	output logic [W-1:0] diff
);

	logic         borrow;
	logic [W-1:0] sub;

	// one subtractor gives both the difference and the compare
	assign {borrow, sub} = {1'b0, a} - {1'b0, b};
	assign diff          = sub;
	assign gt            = !borrow && (sub != '0);

endmodule

@@ hdl/tgps_seq.sv @@
module tgps_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_fire,
	input  logic              serve,
	input  logic              scan_last,
	input  logic              out_free,
	output tgps_pkg::ctl_t    ctl
);

	tgps_pkg::state_t state_q;
	tgps_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgps_pkg::ST_IDLE: begin
				if (item_fire) begin
					state_d = serve ? tgps_pkg::ST_SCAN : tgps_pkg::ST_DONE;
				end
			end
			tgps_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = tgps_pkg::ST_DRAIN;
				end
			end
			tgps_pkg::ST_DRAIN: begin
				state_d = tgps_pkg::ST_DONE;
			end
			tgps_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = tgps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tgps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			tgps_pkg::ST_IDLE:  ctl.ready  = 1'b1;
			tgps_pkg::ST_SCAN:  ctl.scan   = 1'b1;
			tgps_pkg::ST_DRAIN: ctl.drain  = 1'b1;
			tgps_pkg::ST_DONE:  ctl.finish = out_free;
			default:            ctl        = '0;
		endcase
	end

endmodule

@@ hdl/traffic_green_phase_scheduler.sv @@
// channel   direction  handshake                      payload
// item      in         item_valid / item_stall        action, path_index, car_count
// result    out        result_valid / result_stall    granted, green_path, cars_moved,
//                                                     cars_left, green_time, all_clear
// config    in         apb write when psel & penable  cars_per_green at 0, green_seconds at 4
//
// a serve goes from acceptance through the scan and drain states to the result register:
// the shared subtractor looks at one path count per cycle, then once more to drain
// load, clear and unused codes go straight to the done state, then back to idle
// after reset all counts are zero, no path has been served, registers hold 5 and 3
// a stalled result holds the sequencer once a second result is ready; one item is taken
// while an earlier result still waits in the output register
`include "traffic_green_phase_scheduler_assert.svh"

module traffic_green_phase_scheduler #(
	parameter int NUM_PATHS   = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  action,
	input  logic [1:0]  path_index,
	input  logic [15:0] car_count,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        granted,
	output logic [1:0]  green_path,
	output logic [7:0]  cars_moved,
	output logic [15:0] cars_left,
	output logic [7:0]  green_time,
	output logic        all_clear
);

	localparam int IDX_W = $clog2(NUM_PATHS);

	tgps_pkg::ctl_t ctl;

	logic [7:0] cars_per_green_q;
	logic [7:0] green_seconds_q;

	logic [COUNT_WIDTH-1:0] count_q [NUM_PATHS];
	logic [NUM_PATHS-1:0]   nz_q;
	logic [IDX_W-1:0]       last_served_q;
	logic                   last_valid_q;

	logic [IDX_W-1:0]       scan_q;
	logic [IDX_W-1:0]       best_q;
	logic [COUNT_WIDTH-1:0] best_count_q;
	logic [COUNT_WIDTH-1:0] last_cnt_q;
	logic                   found_q;

	logic        res_granted_q;
	logic [1:0]  res_path_q;
	logic [7:0]  res_moved_q;
	logic [15:0] res_left_q;
	logic [7:0]  res_time_q;

	logic                   item_fire;
	logic                   cfg_write;
	logic                   out_free;
	logic                   scan_last;
	logic                   load_ok;
	logic [IDX_W-1:0]       load_idx;
	logic [COUNT_WIDTH-1:0] load_cnt;
	logic [COUNT_WIDTH-1:0] rd_count;
	logic                   skip;
	logic                   grant;
	logic [IDX_W-1:0]       sel;
	logic [COUNT_WIDTH-1:0] have;
	logic [COUNT_WIDTH-1:0] alu_a;
	logic [COUNT_WIDTH-1:0] alu_b;
	logic                   alu_gt;
	logic [COUNT_WIDTH-1:0] alu_diff;
	logic [COUNT_WIDTH-1:0] left;
	logic [7:0]             moved;

	// config port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			tgps_pkg::REG_CARS_PER_GREEN: prdata = {24'd0, cars_per_green_q};
			tgps_pkg::REG_GREEN_SECONDS:  prdata = {24'd0, green_seconds_q};
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cars_per_green_q <= tgps_pkg::CARS_PER_GREEN_RESET;
			green_seconds_q  <= tgps_pkg::GREEN_SECONDS_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				tgps_pkg::REG_CARS_PER_GREEN: cars_per_green_q <= pwdata[7:0];
				tgps_pkg::REG_GREEN_SECONDS:  green_seconds_q  <= pwdata[7:0];
				default:                      cars_per_green_q <= cars_per_green_q;
			endcase
		end
	end

	// sequencer
	assign item_stall = !ctl.ready;
	assign item_fire  = item_valid && ctl.ready;
	assign out_free   = !result_valid || !result_stall;
	assign scan_last  = scan_q == IDX_W'(NUM_PATHS - 1);

	tgps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (item_fire),
		.serve     (action == tgps_pkg::ACT_SERVE),
		.scan_last (scan_last),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	// shared compare and subtract unit
	assign rd_count = count_q[scan_q];
	assign skip     = last_valid_q && (scan_q == last_served_q);
	assign grant    = found_q || (last_valid_q && (last_cnt_q != '0));
	assign sel      = found_q ? best_q : last_served_q;
	assign have     = found_q ? best_count_q : last_cnt_q;
	assign alu_a    = ctl.scan ? rd_count : have;
	assign alu_b    = ctl.scan ? best_count_q : COUNT_WIDTH'(cars_per_green_q);

	tgps_alu #(
		.W (COUNT_WIDTH)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.gt   (alu_gt),
		.diff (alu_diff)
	);

	// more cars than one green moves: drain cars_per_green, else empty the path
	assign left  = alu_gt ? alu_diff : '0;
	assign moved = alu_gt ? cars_per_green_q : 8'(have);

	assign load_ok  = {30'd0, path_index} < 32'(NUM_PATHS);
	assign load_idx = IDX_W'(path_index);
	assign load_cnt = COUNT_WIDTH'(car_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PATHS; i++) begin
				count_q[i] <= '0;
			end
			nz_q          <= '0;
			last_served_q <= '0;
			last_valid_q  <= 1'b0;
			scan_q        <= '0;
		end else begin
			if (item_fire) begin
				if (action == tgps_pkg::ACT_LOAD && load_ok) begin
					count_q[load_idx] <= load_cnt;
					nz_q[load_idx]    <= load_cnt != '0;
				end else if (action == tgps_pkg::ACT_CLEAR) begin
					for (int i = 0; i < NUM_PATHS; i++) begin
						count_q[i] <= '0;
					end
					nz_q          <= '0;
					last_served_q <= '0;
					last_valid_q  <= 1'b0;
				end
			end
			if (ctl.scan) begin
				scan_q <= scan_last ? '0 : scan_q + 1'b1;
			end
			if (ctl.drain && grant) begin
				count_q[sel]  <= left;
				nz_q[sel]     <= left != '0;
				last_served_q <= sel;
				last_valid_q  <= 1'b1;
			end
		end
	end

	// scan and result working registers
	always_ff @(posedge clk) begin
		if (item_fire) begin
			found_q       <= 1'b0;
			best_q        <= '0;
			best_count_q  <= '0;
			last_cnt_q    <= '0;
			res_granted_q <= 1'b0;
			res_path_q    <= '0;
			res_moved_q   <= '0;
			res_left_q    <= '0;
			res_time_q    <= '0;
		end
		if (ctl.scan) begin
			if (scan_q == last_served_q) begin
				last_cnt_q <= rd_count;
			end
			if (!skip && alu_gt) begin
				found_q      <= 1'b1;
				best_q       <= scan_q;
				best_count_q <= rd_count;
			end
		end
		if (ctl.drain && grant) begin
			res_granted_q <= 1'b1;
			res_path_q    <= 2'(sel);
			res_moved_q   <= moved;
			res_left_q    <= 16'(left);
			res_time_q    <= green_seconds_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ctl.finish) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			granted    <= res_granted_q;
			green_path <= res_path_q;
			cars_moved <= res_moved_q;
			cars_left  <= res_left_q;
			green_time <= res_time_q;
			all_clear  <= ~|nz_q;
		end
	end

	`TGPS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_fire, !ctl.ready,
		"sequencer still ready after accepting an item")
	`TGPS_ASSERT_SAME(a_scan_idle_zero, clk, arst_n, ctl.ready, scan_q == '0,
		"scan counter not back at path zero while idle")
	`TGPS_ASSERT_SAME(a_no_grant_zero, clk, arst_n, result_valid && !granted,
		green_path == 2'd0 && cars_moved == 8'd0 && cars_left == 16'd0 && green_time == 8'd0,
		"grant fields not zero without a grant")
	`TGPS_ASSERT_SAME(a_moved_bound, clk, arst_n, result_valid && granted,
		cars_moved <= cars_per_green_q, "more cars moved than one green allows")
	`TGPS_ASSERT_SAME(a_left_not_clear, clk, arst_n,
		result_valid && granted && cars_left != 16'd0, !all_clear,
		"all paths reported clear while the granted path still holds cars")

endmodule
